/* design/drop_oldest_report_fifo_assert.svh */
// assertion macros for the report ring checks
// used by the top level; expects clk and rst_n in scope
`ifndef DROP_OLDEST_REPORT_FIFO_ASSERT_SVH
`define DROP_OLDEST_REPORT_FIFO_ASSERT_SVH

// condition holds at every clock edge out of reset
`define DORF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next
`define DORF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dorf_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the drop-oldest report ring
// no dependencies
package dorf_pkg;

    localparam int DEF_RING_SLOTS       = 16;
    localparam int DEF_MAX_REPORT_BYTES = 64;

    // result kind codes
    localparam logic [1:0] KIND_STORED   = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_BYTE     = 2'd2;
    localparam logic [1:0] KIND_EMPTY    = 2'd3;

    // strobes from the sequencer to the memories
    typedef struct packed {
        logic byte_we;
        logic byte_re;
        logic len_we;
        logic len_re;
    } dorf_mem_ctl_t;

endpackage

/* design/dorf_store.sv */
`timescale 1ns / 1ps
// report byte memory and per-slot length memory, registered reads
// depends on dorf_pkg
module dorf_store #(
    parameter int RING_SLOTS       = dorf_pkg::DEF_RING_SLOTS,
    parameter int MAX_REPORT_BYTES = dorf_pkg::DEF_MAX_REPORT_BYTES,
    parameter int SLOTW            = $clog2(RING_SLOTS + 1),
    parameter int OFFW             = (MAX_REPORT_BYTES > 1) ? $clog2(MAX_REPORT_BYTES) : 1,
    parameter int LENW             = $clog2(MAX_REPORT_BYTES + 1)
) (
    input  logic                    clk,
    input  dorf_pkg::dorf_mem_ctl_t ctl,
    input  logic [SLOTW+OFFW-1:0]   byte_waddr,
    input  logic [7:0]              byte_wdata,
    input  logic [SLOTW+OFFW-1:0]   byte_raddr,
    output logic [7:0]              byte_rdata,
    input  logic [SLOTW-1:0]        len_waddr,
    input  logic [LENW-1:0]         len_wdata,
    input  logic [SLOTW-1:0]        len_raddr,
    output logic [LENW-1:0]         len_rdata
);
    import dorf_pkg::*;

    localparam int PHYS_SLOTS = RING_SLOTS + 1;
    localparam int BYTE_DEPTH = PHYS_SLOTS * (2 ** OFFW);

    logic [7:0]      byte_mem [BYTE_DEPTH];
    logic [LENW-1:0] len_mem  [PHYS_SLOTS];

    always_ff @(posedge clk)
    begin
        if (ctl.byte_we)
        begin
            byte_mem[byte_waddr] <= byte_wdata;
        end
        if (ctl.byte_re)
        begin
            byte_rdata <= byte_mem[byte_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (ctl.len_re)
        begin
            len_rdata <= len_mem[len_raddr];
        end
    end

endmodule

/* design/drop_oldest_report_fifo.sv */
`timescale 1ns / 1ps
// drop-oldest report ring: staging, commit, pop sequencer and result register
// depends on dorf_pkg, dorf_store and drop_oldest_report_fifo_assert.svh
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  input   | in_valid / in_ready | op, data_byte, has_byte, last
//  result  | res_valid/res_ready | kind, out_byte, out_valid, out_last, depth,
//          |                     | dropped_oldest
//
// push w/o last stays idle; push with last or empty-ring pop: via the pending state
// pop of L bytes: length read, then one byte read per cycle while results drain;
// a zero-length report pops via the length read and the pending state
// one item is worked at a time; the sequencer waits on the result register
// a result parked in the result register does not block the next transfer in
// reset clears pointers, counts and staging state; memories are not cleared
`include "drop_oldest_report_fifo_assert.svh"
module drop_oldest_report_fifo #(
    parameter int RING_SLOTS       = dorf_pkg::DEF_RING_SLOTS,
    parameter int MAX_REPORT_BYTES = dorf_pkg::DEF_MAX_REPORT_BYTES,
    parameter int FILLW            = $clog2(RING_SLOTS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             op,
    input  logic [7:0]       data_byte,
    input  logic             has_byte,
    input  logic             last,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [1:0]       kind,
    output logic [7:0]       out_byte,
    output logic             out_valid,
    output logic             out_last,
    output logic [FILLW-1:0] depth,
    output logic             dropped_oldest
);
    import dorf_pkg::*;

    localparam int SLOTW = $clog2(RING_SLOTS + 1);
    localparam int OFFW  = (MAX_REPORT_BYTES > 1) ? $clog2(MAX_REPORT_BYTES) : 1;
    localparam int LENW  = $clog2(MAX_REPORT_BYTES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_EMIT,
        S_PEND
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOTW-1:0]  wp_reg, wp_next;
    logic [SLOTW-1:0]  rp_reg, rp_next;
    logic [FILLW-1:0]  fill_reg, fill_next;
    logic [LENW-1:0]   stage_len_reg, stage_len_next;
    logic              stage_over_reg, stage_over_next;
    logic [SLOTW-1:0]  pop_slot_reg, pop_slot_next;
    logic [LENW-1:0]   pop_len_reg, pop_len_next;
    logic [LENW-1:0]   pop_idx_reg, pop_idx_next;
    logic [1:0]        pend_kind_reg, pend_kind_next;
    logic              pend_drop_reg, pend_drop_next;
    logic              res_valid_reg, res_valid_next;
    logic [1:0]        res_kind_reg, res_kind_next;
    logic [7:0]        res_byte_reg, res_byte_next;
    logic              res_bvalid_reg, res_bvalid_next;
    logic              res_last_reg, res_last_next;
    logic [FILLW-1:0]  res_depth_reg, res_depth_next;
    logic              res_drop_reg, res_drop_next;

    dorf_mem_ctl_t          mem_ctl;
    logic [SLOTW+OFFW-1:0]  byte_waddr;
    logic [SLOTW+OFFW-1:0]  byte_raddr;
    logic [7:0]             byte_rdata;
    logic [LENW-1:0]        len_rdata;

    logic             accept;
    logic             out_free;
    logic             has_room;
    logic [LENW-1:0]  len_after;
    logic             over_after;
    logic             ring_full;
    logic             commit;
    logic             pop_go;
    logic [SLOTW-1:0] wp_inc;
    logic [SLOTW-1:0] rp_inc;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !res_valid_reg || res_ready;
    assign has_room   = stage_len_reg < LENW'(MAX_REPORT_BYTES);
    assign len_after  = stage_len_reg + LENW'(has_byte && has_room);
    assign over_after = stage_over_reg || (has_byte && !has_room);
    assign ring_full  = fill_reg == FILLW'(RING_SLOTS);
    assign commit     = accept && !op && last && !over_after;
    assign pop_go     = accept && op && (fill_reg != '0);

    // the ring has one spare slot, which always holds the report being staged
    assign wp_inc = (wp_reg == SLOTW'(RING_SLOTS)) ? '0 : wp_reg + SLOTW'(1);
    assign rp_inc = (rp_reg == SLOTW'(RING_SLOTS)) ? '0 : rp_reg + SLOTW'(1);

    assign byte_waddr = {wp_reg, stage_len_reg[OFFW-1:0]};

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        fill_next       = fill_reg;
        stage_len_next  = stage_len_reg;
        stage_over_next = stage_over_reg;
        pop_slot_next   = pop_slot_reg;
        pop_len_next    = pop_len_reg;
        pop_idx_next    = pop_idx_reg;
        pend_kind_next  = pend_kind_reg;
        pend_drop_next  = pend_drop_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        res_kind_next   = res_kind_reg;
        res_byte_next   = res_byte_reg;
        res_bvalid_next = res_bvalid_reg;
        res_last_next   = res_last_reg;
        res_depth_next  = res_depth_reg;
        res_drop_next   = res_drop_reg;
        mem_ctl         = '0;
        byte_raddr      = {pop_slot_reg, pop_idx_reg[OFFW-1:0]};

        case (state_reg)
            S_IDLE:
            begin
                if (accept && !op)
                begin
                    mem_ctl.byte_we = has_byte && has_room;
                    stage_len_next  = len_after;
                    stage_over_next = over_after;
                    if (last)
                    begin
                        stage_len_next  = '0;
                        stage_over_next = 1'b0;
                        pend_drop_next  = 1'b0;
                        state_next      = S_PEND;
                        if (over_after)
                        begin
                            pend_kind_next = KIND_REJECTED;
                        end
                        else
                        begin
                            pend_kind_next = KIND_STORED;
                            mem_ctl.len_we = 1'b1;
                            wp_next        = wp_inc;
                            if (ring_full)
                            begin
                                rp_next        = rp_inc;
                                pend_drop_next = 1'b1;
                            end
                            else
                            begin
                                fill_next = fill_reg + FILLW'(1);
                            end
                        end
                    end
                end
                else if (accept && op)
                begin
                    if (fill_reg == '0)
                    begin
                        pend_kind_next = KIND_EMPTY;
                        pend_drop_next = 1'b0;
                        state_next     = S_PEND;
                    end
                    else
                    begin
                        mem_ctl.len_re = 1'b1;
                        pop_slot_next  = rp_reg;
                        rp_next        = rp_inc;
                        fill_next      = fill_reg - FILLW'(1);
                        state_next     = S_LEN;
                    end
                end
            end

            S_LEN:
            begin
                pop_len_next = len_rdata;
                if (len_rdata == '0)
                begin
                    // zero-length report gives one byte-kind result with no byte
                    pend_kind_next = KIND_BYTE;
                    pend_drop_next = 1'b0;
                    state_next     = S_PEND;
                end
                else
                begin
                    mem_ctl.byte_re = 1'b1;
                    byte_raddr      = {pop_slot_reg, {OFFW{1'b0}}};
                    pop_idx_next    = LENW'(1);
                    state_next      = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_kind_next   = KIND_BYTE;
                    res_byte_next   = byte_rdata;
                    res_bvalid_next = 1'b1;
                    res_last_next   = (pop_idx_reg == pop_len_reg);
                    res_depth_next  = fill_reg;
                    res_drop_next   = 1'b0;
                    if (pop_idx_reg == pop_len_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // next byte read overlaps the transfer of this one
                        mem_ctl.byte_re = 1'b1;
                        pop_idx_next    = pop_idx_reg + LENW'(1);
                    end
                end
            end

            S_PEND:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_kind_next   = pend_kind_reg;
                    res_byte_next   = '0;
                    res_bvalid_next = 1'b0;
                    res_last_next   = 1'b1;
                    res_depth_next  = fill_reg;
                    res_drop_next   = pend_drop_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wp_reg         <= '0;
            rp_reg         <= '0;
            fill_reg       <= '0;
            stage_len_reg  <= '0;
            stage_over_reg <= 1'b0;
            pop_slot_reg   <= '0;
            pop_len_reg    <= '0;
            pop_idx_reg    <= '0;
            pend_kind_reg  <= KIND_STORED;
            pend_drop_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_kind_reg   <= KIND_STORED;
            res_byte_reg   <= '0;
            res_bvalid_reg <= 1'b0;
            res_last_reg   <= 1'b0;
            res_depth_reg  <= '0;
            res_drop_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            fill_reg       <= fill_next;
            stage_len_reg  <= stage_len_next;
            stage_over_reg <= stage_over_next;
            pop_slot_reg   <= pop_slot_next;
            pop_len_reg    <= pop_len_next;
            pop_idx_reg    <= pop_idx_next;
            pend_kind_reg  <= pend_kind_next;
            pend_drop_reg  <= pend_drop_next;
            res_valid_reg  <= res_valid_next;
            res_kind_reg   <= res_kind_next;
            res_byte_reg   <= res_byte_next;
            res_bvalid_reg <= res_bvalid_next;
            res_last_reg   <= res_last_next;
            res_depth_reg  <= res_depth_next;
            res_drop_reg   <= res_drop_next;
        end
    end

    dorf_store #(
        .RING_SLOTS       (RING_SLOTS),
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES),
        .SLOTW            (SLOTW),
        .OFFW             (OFFW),
        .LENW             (LENW)
    ) u_store (
        .clk        (clk),
        .ctl        (mem_ctl),
        .byte_waddr (byte_waddr),
        .byte_wdata (data_byte),
        .byte_raddr (byte_raddr),
        .byte_rdata (byte_rdata),
        .len_waddr  (wp_reg),
        .len_wdata  (len_after),
        .len_raddr  (rp_reg),
        .len_rdata  (len_rdata)
    );

    assign res_valid      = res_valid_reg;
    assign kind           = res_kind_reg;
    assign out_byte       = res_byte_reg;
    assign out_valid      = res_bvalid_reg;
    assign out_last       = res_last_reg;
    assign depth          = res_depth_reg;
    assign dropped_oldest = res_drop_reg;

    `DORF_ASSERT_ALWAYS(a_fill_bound, fill_reg <= FILLW'(RING_SLOTS), "ring fill above slot count")
    `DORF_ASSERT_ALWAYS(a_stage_bound, stage_len_reg <= LENW'(MAX_REPORT_BYTES), "stage overrun")
    `DORF_ASSERT_NEXT(a_pop_fill, pop_go, fill_reg == $past(fill_reg) - FILLW'(1), "pop lost count")
    `DORF_ASSERT_NEXT(a_full_commit, commit && ring_full, fill_reg == FILLW'(RING_SLOTS), "drop broke fill")

endmodule
